FILE: src/edc_pkg.sv
package edc_pkg;

  // Reciprocal constants for exact division by multiplication.
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // 2^35 / 675, rounded up
  localparam logic [13:0] HOUR_RECIP  = 14'd9321;      // 2^21 / 225, rounded up
  localparam logic [10:0] MIN_RECIP   = 11'd1093;      // 2^14 / 15, rounded up
  localparam logic [18:0] WEEK_RECIP  = 19'd74899;     // 2^19 / 7, rounded up
  localparam logic [15:0] QUAD_RECIP  = 16'd45934;     // 2^26 / 1461, rounded up

  localparam logic [9:0]  DAY_DIV_HI  = 10'd675;
  localparam logic [16:0] BIAS_REM    = 17'd11648;     // 2^31 mod 86400
  localparam logic [16:0] BIAS_WRAP   = 17'd74752;     // 86400 - 11648
  localparam logic [15:0] WEEK_OFS    = 16'd5;
  localparam logic [15:0] QUAD_OFS    = 16'd346;
  localparam logic [11:0] SECS_HOUR   = 12'd3600;
  localparam logic [5:0]  SECS_MIN    = 6'd60;
  localparam logic [2:0]  DAYS_WEEK   = 3'd7;
  localparam logic [10:0] DAYS_QUAD   = 11'd1461;
  localparam logic [10:0] DAYS_YEAR   = 11'd365;
  localparam logic [10:0] DAYS_YEAR2  = 11'd730;
  localparam logic [10:0] DAYS_YEAR3  = 11'd1095;
  localparam int          NUM_MONTHS  = 12;

  localparam logic [8:0] MONTH_START [NUM_MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Whole days are carried as days since the epoch plus 24856, which is never negative.
  typedef struct packed {
    logic [16:0] tod_sec;
    logic [15:0] day_num;
  } split_t;

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    base = MONTH_START[idx];
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

FILE: src/edc_day_split.sv
module edc_day_split (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [31:0]   secs,
  output edc_pkg::split_t      split
);

  logic [31:0] biased;
  logic [50:0] day_prod;
  logic [24:0] hi_r;
  logic [6:0]  lo_r;
  logic [15:0] quo_r;
  logic [24:0] hi_rem;
  logic [16:0] rem_u;
  edc_pkg::split_t split_nxt;
  edc_pkg::split_t split_r;

  assign biased   = {~secs[31], secs[30:0]};
  assign day_prod = 51'(biased[31:7]) * 51'(edc_pkg::DAY_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r  <= biased[31:7];
      lo_r  <= biased[6:0];
      quo_r <= day_prod[50:35];
    end
  end

  assign hi_rem = hi_r - 25'(quo_r) * 25'(edc_pkg::DAY_DIV_HI);
  assign rem_u  = {hi_rem[9:0], lo_r};

  always_comb begin
    if (rem_u >= edc_pkg::BIAS_REM) begin
      split_nxt.tod_sec = rem_u - edc_pkg::BIAS_REM;
      split_nxt.day_num = quo_r + 16'd1;
    end else begin
      split_nxt.tod_sec = rem_u + edc_pkg::BIAS_WRAP;
      split_nxt.day_num = quo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      split_r <= split_nxt;
    end
  end

  assign split = split_r;

endmodule

FILE: src/edc_clock.sv
module edc_clock (
  input  logic            clk,
  input  logic            en,
  input  logic [16:0]     tod_sec,
  output logic [4:0]      hour,
  output logic [5:0]      minute,
  output logic [5:0]      second
);

  logic [26:0] hour_prod;
  logic [16:0] tod3_r;
  logic [4:0]  hour3_r;
  logic [16:0] in_hour;
  logic [11:0] rest4_r;
  logic [4:0]  hour4_r;
  logic [20:0] min_prod;
  logic [11:0] rest5_r;
  logic [4:0]  hour5_r;
  logic [5:0]  min5_r;
  logic [11:0] sec_full;
  logic [4:0]  hour6_r;
  logic [5:0]  min6_r;
  logic [5:0]  sec6_r;

  assign hour_prod = 27'(tod_sec[16:4]) * 27'(edc_pkg::HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      tod3_r  <= tod_sec;
      hour3_r <= hour_prod[25:21];
    end
  end

  assign in_hour = tod3_r - 17'(hour3_r) * 17'(edc_pkg::SECS_HOUR);

  always_ff @(posedge clk) begin
    if (en) begin
      rest4_r <= in_hour[11:0];
      hour4_r <= hour3_r;
    end
  end

  assign min_prod = 21'(rest4_r[11:2]) * 21'(edc_pkg::MIN_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      rest5_r <= rest4_r;
      hour5_r <= hour4_r;
      min5_r  <= min_prod[19:14];
    end
  end

  assign sec_full = rest5_r - 12'(min5_r) * 12'(edc_pkg::SECS_MIN);

  always_ff @(posedge clk) begin
    if (en) begin
      hour6_r <= hour5_r;
      min6_r  <= min5_r;
      sec6_r  <= sec_full[5:0];
    end
  end

  assign hour   = hour6_r;
  assign minute = min6_r;
  assign second = sec6_r;

endmodule

FILE: src/edc_calendar.sv
module edc_calendar (
  input  logic            clk,
  input  logic            en,
  input  logic [15:0]     day_num,
  output logic [2:0]      weekday,
  output logic [7:0]      year,
  output logic [8:0]      yday,
  output logic [3:0]      month,
  output logic [4:0]      mday
);

  logic [15:0] wk_arg;
  logic [15:0] quad_arg;
  logic [34:0] wk_prod;
  logic [31:0] quad_prod;
  logic [15:0] wk_arg3_r;
  logic [12:0] wk_quo3_r;
  logic [15:0] quad_arg3_r;
  logic [5:0]  quad3_r;
  logic [15:0] wk_rem;
  logic [15:0] quad_rem;
  logic [2:0]  wday4_r;
  logic [10:0] qday4_r;
  logic [5:0]  quad4_r;
  logic [1:0]  yr_in;
  logic [10:0] yday_full;
  logic [2:0]  wday5_r;
  logic [7:0]  year5_r;
  logic [8:0]  yday5_r;
  logic        leap5_r;
  logic [3:0]  mon_nxt;
  logic [8:0]  mday_full;
  logic [2:0]  wday6_r;
  logic [7:0]  year6_r;
  logic [8:0]  yday6_r;
  logic [3:0]  mon6_r;
  logic [4:0]  mday6_r;

  assign wk_arg    = day_num + edc_pkg::WEEK_OFS;
  assign quad_arg  = day_num + edc_pkg::QUAD_OFS;
  assign wk_prod   = 35'(wk_arg) * 35'(edc_pkg::WEEK_RECIP);
  assign quad_prod = 32'(quad_arg) * 32'(edc_pkg::QUAD_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      wk_arg3_r   <= wk_arg;
      wk_quo3_r   <= wk_prod[31:19];
      quad_arg3_r <= quad_arg;
      quad3_r     <= quad_prod[31:26];
    end
  end

  assign wk_rem   = wk_arg3_r - 16'(wk_quo3_r) * 16'(edc_pkg::DAYS_WEEK);
  assign quad_rem = quad_arg3_r - 16'(quad3_r) * 16'(edc_pkg::DAYS_QUAD);

  always_ff @(posedge clk) begin
    if (en) begin
      wday4_r <= wk_rem[2:0];
      qday4_r <= quad_rem[10:0];
      quad4_r <= quad3_r;
    end
  end

  // Each four-year cycle starts in 1901, 1905, ...; its fourth year is the leap year.
  always_comb begin
    if (qday4_r < edc_pkg::DAYS_YEAR) begin
      yr_in = 2'd0;
    end else if (qday4_r < edc_pkg::DAYS_YEAR2) begin
      yr_in = 2'd1;
    end else if (qday4_r < edc_pkg::DAYS_YEAR3) begin
      yr_in = 2'd2;
    end else begin
      yr_in = 2'd3;
    end
  end

  assign yday_full = qday4_r - 11'(yr_in) * edc_pkg::DAYS_YEAR;

  always_ff @(posedge clk) begin
    if (en) begin
      wday5_r <= wday4_r;
      year5_r <= {quad4_r, yr_in} + 8'd1;
      yday5_r <= yday_full[8:0];
      leap5_r <= (yr_in == 2'd3);
    end
  end

  always_comb begin
    mon_nxt = 4'd0;
    for (int i = 1; i < edc_pkg::NUM_MONTHS; i++) begin
      if (yday5_r >= edc_pkg::month_start(leap5_r, 4'(i))) begin
        mon_nxt = 4'(i);
      end
    end
  end

  assign mday_full = yday5_r - edc_pkg::month_start(leap5_r, mon_nxt) + 9'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      wday6_r <= wday5_r;
      year6_r <= year5_r;
      yday6_r <= yday5_r;
      mon6_r  <= mon_nxt;
      mday6_r <= mday_full[4:0];
    end
  end

  assign weekday = wday6_r;
  assign year    = year6_r;
  assign yday    = yday6_r;
  assign month   = mon6_r;
  assign mday    = mday6_r;

endmodule

FILE: src/epoch_seconds_to_utc_date.sv
// Converts a signed 32-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// broken-down UTC date and time: hour, minute, second, weekday (Sunday is 0), year
// since 1900, day of year, month from 0 and day of month.
// The input channel takes one beat per item on in_valid and in_epoch_seconds; the
// result channel returns one beat per item on out_valid and the out_ fields.
// A beat moves when valid is high and stall is low.
// The datapath is a six-stage pipeline: the split into days and seconds of day,
// then the time of day and the calendar side by side, each stage holding one
// constant-reciprocal multiply or one subtract and compare.
// out_valid rises when an accepted beat reaches the last stage, and a new beat is
// accepted in every cycle that is not held, so throughput is one item per clock.
// Reset clears all valid bits; the pipeline is empty afterwards.
// While out_stall holds back a waiting result, the whole pipeline freezes and
// in_stall is raised, so no beat is lost or repeated.
module epoch_seconds_to_utc_date (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_epoch_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_hour_of_day,
  output logic [5:0]         out_minute_of_hour,
  output logic [5:0]         out_second_of_minute,
  output logic [2:0]         out_weekday,
  output logic [7:0]         out_years_since_1900,
  output logic [8:0]         out_day_of_year,
  output logic [3:0]         out_month_index,
  output logic [4:0]         out_day_of_month
);

  localparam int NUM_STAGES = 6;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic                  hold;
  logic                  en;
  edc_pkg::split_t       split;

  assign hold     = vld_r[NUM_STAGES-1] & out_stall;
  assign en       = ~hold;
  assign in_stall = hold;
  assign vld_nxt  = en ? {vld_r[NUM_STAGES-2:0], in_valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  edc_day_split u_split (
    .clk   (clk),
    .en    (en),
    .secs  (in_epoch_seconds),
    .split (split)
  );

  edc_clock u_clock (
    .clk     (clk),
    .en      (en),
    .tod_sec (split.tod_sec),
    .hour    (out_hour_of_day),
    .minute  (out_minute_of_hour),
    .second  (out_second_of_minute)
  );

  edc_calendar u_calendar (
    .clk     (clk),
    .en      (en),
    .day_num (split.day_num),
    .weekday (out_weekday),
    .year    (out_years_since_1900),
    .yday    (out_day_of_year),
    .month   (out_month_index),
    .mday    (out_day_of_month)
  );

  assign out_valid = vld_r[NUM_STAGES-1];

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour_of_day < 5'd24) && (out_minute_of_hour < 6'd60) &&
                  (out_second_of_minute < 6'd60))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weekday < 3'd7) && (out_month_index < 4'd12) &&
                  (out_day_of_month != 5'd0) && (out_day_of_year <= 9'd365) &&
                  (out_years_since_1900 >= 8'd1) && (out_years_since_1900 <= 8'd138))
    else $error("calendar field out of range");

  a_february: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_month_index == 4'd1)) |->
      (out_day_of_month <= 5'd29) &&
      ((out_day_of_month != 5'd29) || (out_years_since_1900[1:0] == 2'd0)))
    else $error("February day does not fit the year");

  a_frozen_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> (vld_r == $past(vld_r)))
    else $error("pipeline moved while the result was held");

endmodule
